>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the classifier.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/msc_pkg.sv
// Package for the MIDI system-exclusive classifier: pattern tables, item types.
// Used by the stream interface, the matcher and the top level.
package msc_pkg;

  localparam int PAT_COUNT  = 4;
  localparam int POS_WIDTH  = 5;
  localparam int POS_DEPTH  = 1 << POS_WIDTH;
  localparam logic [POS_WIDTH-1:0] POS_MAX = POS_WIDTH'(POS_DEPTH - 1);

  // Bit index of each pattern in the alive and hit vectors.
  localparam int PAT_ID_REQUEST   = 0;
  localparam int PAT_ID_REPLY     = 1;
  localparam int PAT_DATA_SET     = 2;
  localparam int PAT_DATA_REQUEST = 3;

  // Bit 8 set marks a wildcard position that accepts any byte.
  localparam logic [8:0] ANY_BYTE = 9'h100;

  // Expected byte per pattern and position; positions past a pattern are wildcards.
  localparam logic [8:0] PAT_TABLE [PAT_COUNT][POS_DEPTH] = '{
    '{0: 9'h0F0, 1: 9'h07E, 3: 9'h006, 4: 9'h001, 5: 9'h0F7, default: ANY_BYTE},
    '{0: 9'h0F0, 1: 9'h07E, 3: 9'h006, 4: 9'h002, 5: 9'h041, 6: 9'h024,
      7: 9'h002, 8: 9'h000, 9: 9'h003, 14: 9'h0F7, default: ANY_BYTE},
    '{0: 9'h0F0, 1: 9'h041, 3: 9'h000, 4: 9'h000, 5: 9'h024, 6: 9'h012,
      default: ANY_BYTE},
    '{0: 9'h0F0, 1: 9'h041, 3: 9'h000, 4: 9'h000, 5: 9'h024, 6: 9'h011,
      16: 9'h0F7, default: ANY_BYTE}
  };

  localparam logic [POS_WIDTH-1:0] PAT_LEN [PAT_COUNT] = '{5'd6, 5'd15, 5'd13, 5'd17};

  // A set bit means the message must end exactly with the pattern.
  localparam logic [PAT_COUNT-1:0] PAT_EXACT = 4'b1011;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } msg_item_t;

  typedef struct packed {
    logic is_identity_request;
    logic is_identity_reply;
    logic is_data_set;
    logic is_data_request;
  } class_item_t;

  // Matcher status: updated still-matching flags and the match flags for a final byte.
  typedef struct packed {
    logic [PAT_COUNT-1:0] alive;
    logic [PAT_COUNT-1:0] hit;
  } match_t;

endpackage

>>> hw/rtl/msc_stream_if.sv
// Valid/ready stream interface carrying one payload item per transfer.
// Depends on msc_pkg for the default payload type.
interface msc_stream_if #(
  parameter type payload_t = msc_pkg::msg_item_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/midi_sysex_message_classifier.sv
// Top level of the MIDI system-exclusive message classifier.
// Depends on msc_pkg, msc_stream_if, msc_match and assert_macros.svh.
//
// Usage:
//   The msg channel takes one message byte per transfer, with final_byte set on
//   the last byte of each message. The result channel gives one item with four
//   match flags for each message, after its final byte. Non-final bytes give no
//   result.
//   Throughput is one byte per cycle while msg.ready is high: the byte position
//   and the still-matching flags update in the cycle a byte is taken, set by a
//   combinational compare against every pattern in the table.
//   The result register is loaded at the edge that takes the final byte and
//   shows the flags in the next cycle.
//   While the receiver stalls, the held result stays in the output register and
//   msg.ready is low; it is high whenever that register is empty or being emptied,
//   so bytes keep flowing while a taken result drains.
//   Reset (synchronous, active high) clears the byte position, sets all
//   still-matching flags and empties the result register; no clearing pass is
//   needed, the block is ready in the first cycle after reset.
`include "assert_macros.svh"

module midi_sysex_message_classifier (
  input logic          clk,
  input logic          rst,
  msc_stream_if.sink   msg,
  msc_stream_if.source result
);
  import msc_pkg::*;

  logic [POS_WIDTH-1:0] byte_position;
  logic [PAT_COUNT-1:0] pattern_alive;
  logic                 out_valid;
  class_item_t          out_item;
  match_t               status;
  logic                 msg_take;

  msc_match u_match (
    .pos       (byte_position),
    .alive     (pattern_alive),
    .data_byte (msg.payload.data_byte),
    .status    (status)
  );

  // msg.ready is high whenever the result register is empty or being emptied.
  assign msg.ready = !out_valid || result.ready;
  assign msg_take  = msg.valid && msg.ready;

  // Message state: position saturates, flags restart after each final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pattern_alive <= '1;
    end else if (msg_take) begin
      if (msg.payload.final_byte) begin
        byte_position <= '0;
        pattern_alive <= '1;
      end else begin
        pattern_alive <= status.alive;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + POS_WIDTH'(1);
        end
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (msg_take && msg.payload.final_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with the match flags on a final byte.
  always_ff @(posedge clk) begin
    if (msg_take && msg.payload.final_byte) begin
      out_item.is_identity_request <= status.hit[PAT_ID_REQUEST];
      out_item.is_identity_reply   <= status.hit[PAT_ID_REPLY];
      out_item.is_data_set         <= status.hit[PAT_DATA_SET];
      out_item.is_data_request     <= status.hit[PAT_DATA_REQUEST];
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

  // A final byte returns the message state to its start values.
  `ASSERT_NEXT(a_restart_after_final, msg_take && msg.payload.final_byte,
    byte_position == '0 && pattern_alive == '1, "state not restarted after final byte")

  // A result appears only after a final byte was taken.
  `ASSERT_ALWAYS(a_result_from_final,
    $rose(out_valid) |-> $past(msg_take && msg.payload.final_byte),
    "result appeared without a final byte")

  // Patterns of different length or with different command bytes never both match.
  `ASSERT_ALWAYS(a_exclusive_flags,
    out_valid |-> !(out_item.is_identity_request && out_item.is_identity_reply) &&
    !(out_item.is_data_set && out_item.is_data_request),
    "mutually exclusive patterns both matched")
endmodule

>>> hw/rtl/msc_match.sv
// Per-byte pattern compare for the classifier: updates the still-matching flags and the match flags.
// Depends on msc_pkg for the pattern tables and the status struct.
module msc_match (
  input  logic [msc_pkg::POS_WIDTH-1:0] pos,
  input  logic [msc_pkg::PAT_COUNT-1:0] alive,
  input  logic [7:0]                    data_byte,
  output msc_pkg::match_t               status
);
  import msc_pkg::*;

  logic [8:0]           entry;
  logic                 keep;
  logic [POS_WIDTH-1:0] last_pos;

  // Compare the byte against every pattern at the current position.
  always_comb begin
    status   = '0;
    entry    = ANY_BYTE;
    keep     = 1'b0;
    last_pos = '0;
    for (int k = 0; k < PAT_COUNT; k++) begin
      entry = PAT_TABLE[k][pos];
      if (pos < PAT_LEN[k]) begin
        keep = entry[8] || (entry[7:0] == data_byte);
      end else begin
        keep = !PAT_EXACT[k];
      end
      status.alive[k] = alive[k] && keep;
      last_pos = PAT_LEN[k] - POS_WIDTH'(1);
      if (PAT_EXACT[k]) begin
        status.hit[k] = status.alive[k] && (pos == last_pos);
      end else begin
        status.hit[k] = status.alive[k] && (pos >= last_pos);
      end
    end
  end
endmodule
